[rtl/core/apl_pkg.sv]
// package for the positional array list
// shared widths, command and status codes, and the control word handed to the cell row
`default_nettype none

package apl_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 3;
    localparam int CNT_W     = 4;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_SEARCH  = 2'd2,
        CMD_DISPLAY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_REJECT    = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
        t_word            value;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/core/apl_cell.sv]
// one entry of the list row: holds a word, shifts to or from its neighbours, compares with the key
// depends on apl_pkg
`default_nettype none

module apl_cell #(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire apl_pkg::t_cell_ctl i_ctl,
    input  wire apl_pkg::t_word    i_left_data,
    input  wire apl_pkg::t_word    i_right_data,
    input  wire logic              i_left_live,
    input  wire logic              i_right_live,
    input  wire logic              i_live,
    output      apl_pkg::t_word    o_data,
    output      logic              o_match
);
    import apl_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  w_take_left;
    logic  w_take_in;
    logic  w_take_right;

    assign w_take_in    = i_ctl.ins && (IDX == int'(i_ctl.pos));
    assign w_take_left  = i_ctl.ins && (IDX > int'(i_ctl.pos)) && i_left_live;
    assign w_take_right = i_ctl.del && (IDX >= int'(i_ctl.pos)) && i_right_live;

    always_comb begin
        n_data = r_data;
        if (w_take_in) begin
            n_data = i_ctl.value;
        end else if (w_take_left) begin
            n_data = i_left_data;
        end else if (w_take_right) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_live && (r_data == i_ctl.value);

endmodule

`default_nettype wire

[rtl/core/apl_ctrl.sv]
// sequencer for the list: length, command decode, search encoder, display walk, output register
// depends on apl_pkg
`default_nettype none

module apl_ctrl #(
    parameter int DEPTH = apl_pkg::DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire apl_pkg::t_cmd                   i_cmd,
    input  wire apl_pkg::t_word                  i_value,
    input  wire logic [apl_pkg::POS_W-1:0]       i_pos,
    input  wire logic [DEPTH-1:0]                i_match,
    input  wire logic [DEPTH-1:0][apl_pkg::WORD_W-1:0] i_cells,
    output      apl_pkg::t_cell_ctl              o_ctl,
    output      logic [DEPTH-1:0]                o_live,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      apl_pkg::t_status                o_status,
    output      logic [apl_pkg::POS_W-1:0]       o_found_index,
    output      apl_pkg::t_word                  o_element,
    output      logic [apl_pkg::CNT_W-1:0]       o_count,
    output      logic                            o_last
);
    import apl_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    t_state          r_state;
    t_state          n_state;
    logic [LW-1:0]   r_len;
    logic [LW-1:0]   n_len;
    logic [IW-1:0]   r_disp;
    logic [IW-1:0]   n_disp;
    logic            r_out_valid;
    t_status         r_status;
    t_status         n_status;
    logic [POS_W-1:0] r_found;
    logic [POS_W-1:0] n_found;
    t_word           r_elem;
    t_word           n_elem;
    logic            r_last;
    logic            n_last;
    logic            w_load;
    logic            w_out_free;
    logic            w_accept;
    logic            w_ins_ok;
    logic            w_del_ok;
    logic            w_hit;
    logic [IW-1:0]   w_hit_idx;
    logic            w_disp_end;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ins_ok = (r_len < LW'(DEPTH)) && (CW'(i_pos) <= CW'(r_len));
    assign w_del_ok = CW'(i_pos) < CW'(r_len);
    assign w_disp_end = (LW'(r_disp) + LW'(1)) == r_len;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_live[i] = LW'(i) < r_len;
        end
    end

    // last matching entry wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_match[i]) begin
                w_hit     = 1'b1;
                w_hit_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cmd == CMD_DISPLAY) && (r_len > LW'(1))) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (w_out_free && w_disp_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_load      = 1'b0;
        o_ctl.ins   = 1'b0;
        o_ctl.del   = 1'b0;
        o_ctl.pos   = i_pos;
        o_ctl.value = i_value;
        n_len       = r_len;
        n_disp      = r_disp;
        n_status    = STS_OK;
        n_found     = '0;
        n_elem      = '0;
        n_last      = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            if (w_ins_ok) begin
                                o_ctl.ins = 1'b1;
                                n_len     = r_len + LW'(1);
                            end else begin
                                n_status = STS_REJECT;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_len == '0) begin
                                n_status = STS_EMPTY;
                            end else if (w_del_ok) begin
                                o_ctl.del = 1'b1;
                                n_len     = r_len - LW'(1);
                            end else begin
                                n_status = STS_REJECT;
                            end
                        end
                        CMD_SEARCH: begin
                            if (w_hit) begin
                                n_found = POS_W'(w_hit_idx);
                            end else begin
                                n_status = STS_NOT_FOUND;
                            end
                        end
                        CMD_DISPLAY: begin
                            if (r_len == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_elem = i_cells[0];
                                n_last = (r_len == LW'(1));
                                n_disp = IW'(1);
                            end
                        end
                        default: n_status = STS_REJECT;
                    endcase
                end
            end
            ST_DISP: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_elem = i_cells[r_disp];
                    n_last = w_disp_end;
                    n_disp = r_disp + IW'(1);
                end
            end
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_disp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_disp  <= n_disp;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_elem   <= n_elem;
            r_last   <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_element     = r_elem;
    assign o_last        = r_last;
    assign o_count       = CNT_W'(r_len);

endmodule

`default_nettype wire

[rtl/core/positional_array_list_top.sv]
// top level of the positional array list: a row of DEPTH cells and the sequencer
// depends on apl_pkg, apl_cell and apl_ctrl
`default_nettype none

// An ordered list of up to DEPTH unsigned 32-bit words. Insert, delete and search act on every
// cell at once: each cell shifts or compares in parallel, and the result word sits in an output
// register so the next command is taken in the same cycle the previous result leaves. Display
// holds the input while the walk reads one stored entry per cycle into the output register, as
// long as the output is not stalled; an empty list gives a single word. Results come out in
// command order, the final word of each command with m_tlast high; count is the list length modulo 16.

module positional_array_list_top #(
    parameter int DEPTH = apl_pkg::DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [apl_pkg::S_DATA_W-1:0] s_tdata,  // value[31:0], position[34:32], zero pad
    input  wire logic [1:0]                   s_tuser,  // cmd[1:0]
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [apl_pkg::M_DATA_W-1:0] m_tdata,  // found_index[2:0], element[34:3],
                                                        // count[38:35], zero pad
    output      logic [1:0]                   m_tuser,  // status[1:0]
    output      logic                         m_tlast
);
    import apl_pkg::*;

    t_cell_ctl                   w_ctl;
    logic [DEPTH-1:0]            w_live;
    logic [DEPTH-1:0]            w_match;
    logic [DEPTH-1:0][WORD_W-1:0] w_cells;
    t_status                     w_status;
    logic [POS_W-1:0]            w_found;
    t_word                       w_elem;
    logic [CNT_W-1:0]            w_count;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        logic  w_left_live;
        logic  w_right_live;

        if (g == 0) begin : g_first
            assign w_left      = '0;
            assign w_left_live = 1'b0;
        end else begin : g_inner_l
            assign w_left      = w_cells[g-1];
            assign w_left_live = w_live[g-1];
        end

        if (g == DEPTH - 1) begin : g_final
            assign w_right      = '0;
            assign w_right_live = 1'b0;
        end else begin : g_inner_r
            assign w_right      = w_cells[g+1];
            assign w_right_live = w_live[g+1];
        end

        apl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_left_live  (w_left_live),
            .i_right_live (w_right_live),
            .i_live       (w_live[g]),
            .o_data       (w_cells[g]),
            .o_match      (w_match[g])
        );
    end

    apl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_tvalid),
        .o_in_ready    (s_tready),
        .i_cmd         (t_cmd'(s_tuser)),
        .i_value       (s_tdata[WORD_W-1:0]),
        .i_pos         (s_tdata[WORD_W+POS_W-1:WORD_W]),
        .i_match       (w_match),
        .i_cells       (w_cells),
        .o_ctl         (w_ctl),
        .o_live        (w_live),
        .o_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .o_status      (w_status),
        .o_found_index (w_found),
        .o_element     (w_elem),
        .o_count       (w_count),
        .o_last        (m_tlast)
    );

    assign m_tuser = w_status;
    assign m_tdata = {{(M_DATA_W-CNT_W-WORD_W-POS_W){1'b0}}, w_count, w_elem, w_found};

endmodule

`default_nettype wire

[sim/positional_array_list_top_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for positional_array_list_top: list commands over the input stream,
// a shadow list predicting every result word, and a scoreboard on the output stream
// depends on apl_pkg and the rtl of positional_array_list_top

module positional_array_list_top_tb;

    import apl_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int HOLD_CYCLES = 64;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RAND_ITEMS  = 290;
    localparam int PHASE_ITEMS = 58;

    typedef enum logic [1:0] {
        PACE_FLAT,
        PACE_SRC,
        PACE_SNK,
        PACE_BOTH
    } t_pace;

    typedef struct {
        t_cmd             cmd;
        t_word            value;
        logic [POS_W-1:0] pos;
        bit               drain;
        bit               hold;
        t_pace            pace;
    } t_list_cmd;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] found_index;
        t_word            element;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_list_word;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = CMD_INSERT;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    t_list_cmd  queued_commands[$];
    t_list_word pending_list_words[$];
    t_word      shadow_cells[LIST_DEPTH];
    int         shadow_len     = 0;
    int         plan_len       = 0;
    int         commands_total = 0;
    int         commands_taken = 0;
    int         mismatches     = 0;
    int         idle_cycles    = 0;
    int         hold_asked     = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;
    logic       in_taken       = 1'b0;
    t_pace      cur_pace       = PACE_FLAT;

    positional_array_list_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic void apply_list_command(t_cmd cmd, t_word value, logic [POS_W-1:0] pos);
        t_list_word w;
        int         i;
        int         hit;
        w.status      = STS_OK;
        w.found_index = '0;
        w.element     = '0;
        w.last        = 1'b1;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_len >= LIST_DEPTH || int'(pos) > shadow_len) begin
                    w.status = STS_REJECT;
                end else begin
                    for (i = shadow_len; i > int'(pos); i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = value;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (shadow_len == 0) begin
                    w.status = STS_EMPTY;
                end else if (int'(pos) >= shadow_len) begin
                    w.status = STS_REJECT;
                end else begin
                    for (i = int'(pos) + 1; i < shadow_len; i++)
                        shadow_cells[i-1] = shadow_cells[i];
                    shadow_len--;
                end
            end
            CMD_SEARCH: begin
                hit = -1;
                for (i = 0; i < shadow_len; i++)
                    if (shadow_cells[i] == value) hit = i;
                if (hit < 0) w.status = STS_NOT_FOUND;
                else w.found_index = hit[POS_W-1:0];
            end
            default: begin
                if (shadow_len == 0) w.status = STS_EMPTY;
            end
        endcase
        w.count = shadow_len[CNT_W-1:0];
        if (cmd == CMD_DISPLAY && shadow_len != 0) begin
            for (i = 0; i < shadow_len; i++) begin
                w.element = shadow_cells[i];
                w.last    = (i == shadow_len - 1);
                pending_list_words.push_back(w);
            end
        end else begin
            pending_list_words.push_back(w);
        end
    endfunction

    task automatic queue_command(t_cmd cmd, t_word value, int pos, bit drain, bit hold,
                                 t_pace pace);
        t_list_cmd c;
        c.cmd   = cmd;
        c.value = value;
        c.pos   = pos[POS_W-1:0];
        c.drain = drain;
        c.hold  = hold;
        c.pace  = pace;
        queued_commands.push_back(c);
        commands_total++;
        if (cmd == CMD_INSERT && plan_len < LIST_DEPTH && pos <= plan_len) plan_len++;
        if (cmd == CMD_DELETE && plan_len > 0 && pos < plan_len) plan_len--;
    endtask

    // sender: next word offered once the previous one has gone
    always @(negedge i_clk) begin : drive_proc
        t_list_cmd c;
        logic      offer;
        int        idle_pct;
        offer    = s_tvalid && !in_taken;
        idle_pct = (cur_pace == PACE_SRC) ? 80 : (cur_pace == PACE_BOTH) ? 34 : 0;
        if (i_rst_n && !offer && queued_commands.size() != 0) begin
            if (!(queued_commands[0].drain && pending_list_words.size() != 0) &&
                    $urandom_range(99) >= idle_pct) begin
                c       = queued_commands.pop_front();
                offer   = 1'b1;
                s_tuser <= c.cmd;
                s_tdata <= {{(S_DATA_W-WORD_W-POS_W){1'b0}}, c.pos, c.value};
                cur_pace <= c.pace;
                if (c.hold) hold_asked <= hold_asked + 1;
            end
        end
        s_tvalid <= offer;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin : sink_proc
        int stall_pct;
        stall_pct = (cur_pace == PACE_SNK) ? 80 : (cur_pace == PACE_BOTH) ? 34 : 0;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : score_proc
        t_list_word got;
        t_list_word want;
        in_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            apply_list_command(t_cmd'(s_tuser), s_tdata[WORD_W-1:0], s_tdata[WORD_W +: POS_W]);
            commands_taken++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status      = t_status'(m_tuser);
            got.found_index = m_tdata[POS_W-1:0];
            got.element     = m_tdata[POS_W +: WORD_W];
            got.count       = m_tdata[POS_W+WORD_W +: CNT_W];
            got.last        = m_tlast;
            if (pending_list_words.size() == 0) begin
                $display("%0t unexpected word: expected none, got sts=%0d idx=%0d elem=%h cnt=%0d last=%b",
                         $time, got.status, got.found_index, got.element, got.count, got.last);
                mismatches++;
            end else begin
                want = pending_list_words.pop_front();
                if (got.status !== want.status || got.found_index !== want.found_index ||
                        got.element !== want.element || got.count !== want.count ||
                        got.last !== want.last) begin
                    $display("%0t word mismatch: expected sts=%0d idx=%0d elem=%h cnt=%0d last=%b, got sts=%0d idx=%0d elem=%h cnt=%0d last=%b",
                             $time, want.status, want.found_index, want.element, want.count,
                             want.last, got.status, got.found_index, got.element, got.count,
                             got.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus_proc
        t_word pool[8];
        t_word v;
        t_cmd  c;
        t_pace p;
        int    n;
        int    r;
        int    ins_w;
        int    pos;

        // directed: empty list, bounds, extremes, duplicates, full list
        queue_command(CMD_DISPLAY, 32'h0,         0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DELETE,  32'h0,         0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_SEARCH,  32'h0,         0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h5,         1, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h8000_0000, 0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h7fff_ffff, 1, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'hffff_ffff, 1, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h5,         0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h5,         4, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h0,         2, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h5,         6, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h5555_aaaa, 7, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'h1,         3, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_SEARCH,  32'h5,         7, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_SEARCH,  32'h8000_0000, 0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_SEARCH,  32'h0001_2345, 0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DISPLAY, 32'h0,         0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DELETE,  32'h0,         7, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DELETE,  32'h0,         7, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DELETE,  32'h0,         0, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_INSERT,  32'haaaa_5555, 7, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DELETE,  32'h0,         2, 1'b0, 1'b0, PACE_FLAT);
        queue_command(CMD_DISPLAY, 32'h0,         0, 1'b0, 1'b0, PACE_FLAT);

        pool[0] = 32'h0;
        pool[1] = 32'h1;
        pool[2] = 32'hffff_ffff;
        pool[3] = 32'h8000_0000;
        pool[4] = 32'h7fff_ffff;
        pool[5] = 32'h5;
        pool[6] = 32'h5555_aaaa;
        pool[7] = 32'hdead_beef;

        for (n = 0; n < RAND_ITEMS; n++) begin
            case (n / PHASE_ITEMS)
                1:       p = PACE_SRC;
                2:       p = PACE_SNK;
                3:       p = PACE_BOTH;
                default: p = PACE_FLAT;
            endcase
            v     = ($urandom_range(2) == 0) ? $urandom : pool[$urandom_range(7)];
            ins_w = (plan_len >= 6) ? 25 : 45;
            r     = $urandom_range(99);
            if (r < ins_w) begin
                c   = CMD_INSERT;
                pos = ($urandom_range(9) == 0) ? $urandom_range(7)
                    : $urandom_range((plan_len > 7) ? 7 : plan_len);
            end else if (r < ins_w + 25) begin
                c   = CMD_DELETE;
                pos = ($urandom_range(9) == 0 || plan_len == 0) ? $urandom_range(7)
                    : $urandom_range(plan_len - 1);
            end else if (r < ins_w + 45) begin
                c   = CMD_SEARCH;
                pos = $urandom_range(7);
            end else begin
                c   = CMD_DISPLAY;
                pos = $urandom_range(7);
            end
            queue_command(c, v, pos, (n % PHASE_ITEMS == 0), (n == 20), p);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (commands_taken != commands_total) @(posedge i_clk);
        while (pending_list_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_list_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
